[rtl/l2_l4_header_parser_unit_defines.svh]
// ---------------------------------------------------------------------------
// L2-L4 header parser: assertion macros
// Shorthand for the concurrent checks of the parser, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef L2_L4_HEADER_PARSER_UNIT_DEFINES_SVH
`define L2_L4_HEADER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define L2L4HP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("l2l4hp: same-cycle check failed");

// Next-cycle implication.
`define L2L4HP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("l2l4hp: next-cycle check failed");

`endif

[rtl/l2l4hp_pkg.sv]
// ---------------------------------------------------------------------------
// L2-L4 header parser package
// Types, protocol constants and codes shared by the parser modules.
// ---------------------------------------------------------------------------
package l2l4hp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_L2   = 3'd1,
    PH_IPV4 = 3'd2,
    PH_IPV6 = 3'd3,
    PH_L4   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ETYPE = 3'd1,
    ST_IHL   = 3'd2,
    ST_PROTO = 3'd3,
    ST_SHORT = 3'd4,
    ST_TRUNC = 3'd5
  } status_t;

  localparam logic [1:0] L2_QINQ  = 2'd2;
  localparam logic [1:0] L3_IPV4  = 2'd1;
  localparam logic [1:0] L3_IPV6  = 2'd2;
  localparam logic [1:0] L4_NONE  = 2'd0;
  localparam logic [1:0] L4_TCP   = 2'd1;
  localparam logic [1:0] L4_UDP   = 2'd2;

  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0] IPV6_HDR_LEN   = 8'd40;
  localparam logic [7:0] UDP_HDR_LEN    = 8'd8;
  localparam logic [3:0] IPV4_MIN_IHL   = 4'd5;
  localparam logic [7:0] IPV4_TLEN_OFS  = 8'd3;   // second byte of total length
  localparam logic [7:0] IPV4_PROTO_OFS = 8'd9;
  localparam logic [7:0] IPV6_PLEN_OFS  = 8'd5;   // second byte of payload length
  localparam logic [7:0] IPV6_NXTH_OFS  = 8'd6;
  localparam logic [7:0] TCP_DOFF_OFS   = 8'd12;
  localparam logic [7:0] IP_PROTO_TCP   = 8'd6;
  localparam logic [7:0] IP_PROTO_UDP   = 8'd17;
  localparam logic [7:0] BYTE_POS_MAX   = 8'hff;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  byte_pos;
    logic [15:0] type_shift;
    logic [7:0]  l3_end;
    logic [7:0]  next_proto;
    logic [15:0] len_word;
    logic [7:0]  l4_end;
    logic [1:0]  l2_kind;
    logic [1:0]  l3_kind;
    logic [1:0]  l4_kind;
  } parse_state_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
    logic [1:0]  l2_kind;
    logic [1:0]  l3_kind;
    logic [1:0]  l4_kind;
  } result_t;

endpackage

[rtl/l2_l4_header_parser_unit.sv]
// ---------------------------------------------------------------------------
// L2-L4 header parser
// Streaming Ethernet / VLAN / QinQ / IPv4 / IPv6 / TCP / UDP header parser,
// one packet byte per transaction, at most one result transaction per packet.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | input     | in_valid/in_stall  | data_byte, start_of_packet, end_of_packet
//  out_    | output    | out_valid/out_stall| status, payload_offset, payload_length,
//          |           |                    | l2_kind, l3_kind, l4_kind
//
//  Throughput: one byte per cycle while in_stall is low. An accepted byte
//  reaches its result through the input register, then the result register.
//  The rate is set by the parser state update.
//  Reset (rst_n low, synchronous) empties both registers and returns the
//  parser to idle, waiting for a start of packet.
//  in_stall is raised only when the byte in the input register completes a
//  packet result and the result register is still held by out_stall.
//
`include "l2_l4_header_parser_unit_defines.svh"

module l2_l4_header_parser_unit import l2l4hp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_packet,
  input  logic        in_end_of_packet,
  // per-packet result out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_payload_offset,
  output logic [15:0] out_payload_length,
  output logic [1:0]  out_l2_kind,
  output logic [1:0]  out_l3_kind,
  output logic [1:0]  out_l4_kind
);

  // Input register: one byte waiting for the parser step.
  logic         s1_valid_r;
  logic         s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_sop_r;
  logic         s1_eop_r;

  // Parser state, advanced once per byte.
  parse_state_t state_r;
  parse_state_t state_nxt;

  logic         res_valid;
  result_t      res;
  logic         obuf_ready;
  result_t      obuf_data;
  logic         adv;

  // A byte moves through the step unless it carries a result and the
  // result register cannot take it.
  assign adv      = s1_valid_r && (!res_valid || obuf_ready);
  assign in_stall = s1_valid_r && !adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_sop_r  <= in_start_of_packet;
      s1_eop_r  <= in_end_of_packet;
    end
  end

  l2l4hp_step u_step (
    .cur_state (state_r),
    .data_byte (s1_byte_r),
    .sop       (s1_sop_r),
    .eop       (s1_eop_r),
    .nxt_state (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // Parser state only moves when its byte leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  l2l4hp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (obuf_data),
    .ready     (obuf_ready)
  );

  assign out_status         = obuf_data.status;
  assign out_payload_offset = obuf_data.payload_offset;
  assign out_payload_length = obuf_data.payload_length;
  assign out_l2_kind        = obuf_data.l2_kind;
  assign out_l3_kind        = obuf_data.l3_kind;
  assign out_l4_kind        = obuf_data.l4_kind;

  // A result always closes the packet.
  `L2L4HP_ASSERT_NEXT(a_result_closes, adv && res_valid, state_r.phase == PH_IDLE)

  // Only a result-bearing byte blocked by a held result may stall the input.
  `L2L4HP_ASSERT_SAME(a_stall_cause, in_stall, res_valid && out_valid && out_stall)

  // Error results carry no offset and no length.
  `L2L4HP_ASSERT_SAME(a_err_fields, out_valid && (out_status != ST_OK), (out_payload_offset == 8'd0) && (out_payload_length == 16'd0))

  // Bytes outside a packet leave the parser untouched.
  `L2L4HP_ASSERT_NEXT(a_idle_hold, adv && !s1_sop_r && (state_r.phase == PH_IDLE), $stable(state_r))

endmodule

[rtl/l2l4hp_step.sv]
// ---------------------------------------------------------------------------
// L2-L4 header parser: per-byte step
// Next parser state and the packet result for one byte.
// ---------------------------------------------------------------------------
module l2l4hp_step import l2l4hp_pkg::*; (
  input  parse_state_t cur_state,
  input  logic [7:0]   data_byte,
  input  logic         sop,
  input  logic         eop,
  output parse_state_t nxt_state,
  output logic         res_valid,
  output result_t      res
);

  parse_state_t base;
  parse_state_t nxt;
  logic [7:0]   p;
  logic [8:0]   p_inc;
  logic [7:0]   l3_start;
  logic [7:0]   rel;
  logic [7:0]   hlen;
  logic [7:0]   ihl_bytes;
  logic [7:0]   doff;
  logic [15:0]  ts;
  logic         proto_at;
  logic         hit;
  status_t      stat;

  // A start byte restarts parsing from a clean state.
  always_comb begin
    base = cur_state;
    if (sop) begin
      base       = '0;
      base.phase = PH_L2;
    end
  end

  assign p         = base.byte_pos;
  assign p_inc     = {1'b0, p} + 9'd1;
  assign ts        = {base.type_shift[7:0], data_byte};
  assign l3_start  = ETH_HDR_LEN + {4'd0, base.l2_kind, 2'd0};
  assign rel       = p - ((base.phase == PH_L4) ? base.l3_end : l3_start);
  assign hlen      = base.l3_end - l3_start;
  assign ihl_bytes = {2'd0, data_byte[3:0], 2'd0};
  assign doff      = {2'd0, data_byte[7:4], 2'd0};
  assign proto_at  = ((base.phase == PH_IPV4) && (rel == IPV4_PROTO_OFS)) ||
                     ((base.phase == PH_IPV6) && (rel == IPV6_NXTH_OFS));

  always_comb begin : next_state
    nxt  = base;
    hit  = 1'b0;
    stat = ST_OK;
    if (base.phase != PH_IDLE) begin
      nxt.type_shift = ts;

      // protocol / next header byte, same handling for both IP versions
      if (proto_at) begin
        nxt.next_proto = data_byte;
        if (data_byte == IP_PROTO_UDP) begin
          if (base.len_word < {8'd0, UDP_HDR_LEN}) begin
            hit  = 1'b1;
            stat = ST_SHORT;
          end else begin
            nxt.len_word = base.len_word - {8'd0, UDP_HDR_LEN};
            nxt.l4_end   = base.l3_end + UDP_HDR_LEN;
            nxt.l4_kind  = L4_UDP;
          end
        end else if (data_byte != IP_PROTO_TCP) begin
          hit  = 1'b1;
          stat = ST_PROTO;
        end
      end

      unique case (base.phase)
        PH_L2: begin
          if (p == l3_start - 8'd1) begin
            if ((ts == ETYPE_VLAN) && (base.l2_kind < L2_QINQ)) begin
              nxt.l2_kind = base.l2_kind + 2'd1;
            end else if (ts == ETYPE_IPV4) begin
              nxt.phase = PH_IPV4;
            end else if (ts == ETYPE_IPV6) begin
              nxt.phase   = PH_IPV6;
              nxt.l3_kind = L3_IPV6;
              nxt.l3_end  = l3_start + IPV6_HDR_LEN;
            end else begin
              hit  = 1'b1;
              stat = ST_ETYPE;
            end
          end
        end
        PH_IPV4: begin
          if (rel == 8'd0) begin
            if (data_byte[3:0] < IPV4_MIN_IHL) begin
              hit  = 1'b1;
              stat = ST_IHL;
            end else begin
              nxt.l3_end  = l3_start + ihl_bytes;
              nxt.l3_kind = L3_IPV4;
            end
          end else if (rel == IPV4_TLEN_OFS) begin
            if (ts < {8'd0, hlen}) begin
              hit  = 1'b1;
              stat = ST_SHORT;
            end else begin
              nxt.len_word = ts - {8'd0, hlen};
            end
          end
          if (!hit && (rel >= IPV4_PROTO_OFS) && (p_inc == {1'b0, base.l3_end})) begin
            nxt.phase = PH_L4;
          end
        end
        PH_IPV6: begin
          if (rel == IPV6_PLEN_OFS) begin
            nxt.len_word = ts;
          end
          if (!hit && (p_inc == {1'b0, base.l3_end})) begin
            nxt.phase = PH_L4;
          end
        end
        PH_L4: begin
          if ((base.next_proto == IP_PROTO_TCP) && (rel == TCP_DOFF_OFS)) begin
            if (base.len_word < {8'd0, doff}) begin
              hit  = 1'b1;
              stat = ST_SHORT;
            end else begin
              nxt.len_word = base.len_word - {8'd0, doff};
              nxt.l4_end   = base.l3_end + doff;
              nxt.l4_kind  = L4_TCP;
            end
          end
          if (!hit && (nxt.l4_kind != L4_NONE) && (p_inc >= {1'b0, nxt.l4_end})) begin
            hit  = 1'b1;
            stat = ST_OK;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
        end
      endcase

      nxt.byte_pos = (p == BYTE_POS_MAX) ? p : p + 8'd1;

      if (!hit && eop) begin
        hit  = 1'b1;
        stat = ST_TRUNC;
      end
      if (eop || hit) begin
        nxt.phase = PH_IDLE;
      end
    end
  end

  always_comb begin : result_out
    res_valid          = hit;
    res.status         = stat;
    res.payload_offset = (stat == ST_OK) ? nxt.l4_end : 8'd0;
    res.payload_length = (stat == ST_OK) ? nxt.len_word : 16'd0;
    res.l2_kind        = nxt.l2_kind;
    res.l3_kind        = nxt.l3_kind;
    res.l4_kind        = nxt.l4_kind;
  end

  assign nxt_state = nxt;

endmodule

[rtl/l2l4hp_obuf.sv]
// ---------------------------------------------------------------------------
// L2-L4 header parser: result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module l2l4hp_obuf import l2l4hp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_data,
  output logic    ready
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  // free now, or emptied at this edge
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// L2-L4 header parser testbench
// Streams hand-built and random Ethernet / VLAN / IP / TCP / UDP frames into
// the parser one byte per transaction. A local parser model predicts the
// result of each packet. The result stream is checked field by field while
// the source pauses at random and the sink stalls at random.
// ---------------------------------------------------------------------------
module tb_top;
  import l2l4hp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MIN_BYTES    = 800;
  localparam int MIN_FRAMES   = 60;
  localparam int REPORT_MAX   = 10;

  // Values used only to build broken frames.
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_ICMP6 = 8'd58;

  // One byte transaction as presented on the in_ channel.
  typedef struct packed {
    logic [7:0] data;
    logic       sop;
    logic       eop;
  } wire_byte_t;

  // Sink behaviour, changed every so often.
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_start_of_packet = 1'b0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_payload_offset;
  logic [15:0] out_payload_length;
  logic [1:0]  out_l2_kind;
  logic [1:0]  out_l3_kind;
  logic [1:0]  out_l4_kind;

  l2_l4_header_parser_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_packet (in_start_of_packet),
    .in_end_of_packet   (in_end_of_packet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_l2_kind        (out_l2_kind),
    .out_l3_kind        (out_l3_kind),
    .out_l4_kind        (out_l4_kind)
  );

  always #CLK_HALF clk = ~clk;

  // Byte transactions waiting to be driven, and packet results waiting to
  // come out of the block, oldest first.
  wire_byte_t  tx_bytes[$];
  result_t     pending_results[$];
  logic [7:0]  frame[$];            // frame under construction
  int          sent_bytes  = 0;
  int          frames_sent = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  // -------------------------------------------------------------------------
  // Parser model: its own copy of the parse state, one call per accepted byte
  // -------------------------------------------------------------------------
  phase_t      prs_phase  = PH_IDLE;
  logic [7:0]  prs_pos    = '0;
  logic [15:0] prs_shift  = '0;     // last two bytes seen
  logic [7:0]  prs_l3_end = '0;
  logic [7:0]  prs_proto  = '0;
  logic [15:0] prs_len    = '0;     // IP length less the headers so far
  logic [7:0]  prs_l4_end = '0;
  logic [1:0]  prs_l2     = '0;
  logic [1:0]  prs_l3     = '0;
  logic [1:0]  prs_l4     = '0;
  bit          prs_done   = 1'b0;   // this packet has given its result

  // Protocol byte of either IP version. Returns 1 when it ends the packet.
  function automatic bit take_l4_proto(input logic [7:0] b, output status_t st);
    st = ST_PROTO;
    prs_proto = b;
    if (b == IP_PROTO_TCP) return 1'b0;
    if (b == IP_PROTO_UDP) begin
      if (prs_len < UDP_HDR_LEN) begin
        st = ST_SHORT;
        return 1'b1;
      end
      prs_len    = prs_len - UDP_HDR_LEN;
      prs_l4_end = prs_l3_end + UDP_HDR_LEN;
      prs_l4     = L4_UDP;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_parse(input logic [7:0] b, input logic sop,
                                        input logic eop);
    bit      hit;
    status_t st;
    int      p, l3start, r, ihl, hlen, doff;
    result_t res;
    hit = 1'b0;
    st  = ST_OK;
    // a start of packet throws away whatever was going on
    if (sop) begin
      prs_phase  = PH_L2;
      prs_pos    = '0;
      prs_shift  = '0;
      prs_l3_end = '0;
      prs_proto  = '0;
      prs_len    = '0;
      prs_l4_end = '0;
      prs_l2     = '0;
      prs_l3     = '0;
      prs_l4     = '0;
      prs_done   = 1'b0;
    end
    if (prs_phase == PH_IDLE || prs_done) return;

    p         = prs_pos;
    prs_shift = {prs_shift[7:0], b};
    l3start   = ETH_HDR_LEN + 4 * prs_l2;

    case (prs_phase)
      PH_L2: begin
        if (p == l3start - 1) begin
          if (prs_shift == ETYPE_VLAN && prs_l2 < L2_QINQ) begin
            prs_l2 = prs_l2 + 2'd1;
          end else if (prs_shift == ETYPE_IPV4) begin
            prs_phase = PH_IPV4;
          end else if (prs_shift == ETYPE_IPV6) begin
            prs_phase  = PH_IPV6;
            prs_l3     = L3_IPV6;
            prs_l3_end = l3start + IPV6_HDR_LEN;
          end else begin
            hit = 1'b1;
            st  = ST_ETYPE;
          end
        end
      end
      PH_IPV4: begin
        r = (p - l3start) & 255;
        if (r == 0) begin
          ihl = b[3:0];
          if (ihl < IPV4_MIN_IHL) begin
            hit = 1'b1;
            st  = ST_IHL;
          end else begin
            prs_l3_end = l3start + ihl * 4;
            prs_l3     = L3_IPV4;
          end
        end else if (r == IPV4_TLEN_OFS) begin
          hlen = prs_l3_end - l3start;
          if (prs_shift < hlen) begin
            hit = 1'b1;
            st  = ST_SHORT;
          end else begin
            prs_len = prs_shift - hlen;
          end
        end else if (r == IPV4_PROTO_OFS) begin
          hit = take_l4_proto(b, st);
        end
        if (!hit && r >= IPV4_PROTO_OFS && p + 1 == prs_l3_end) prs_phase = PH_L4;
      end
      PH_IPV6: begin
        r = (p - l3start) & 255;
        if (r == IPV6_PLEN_OFS) prs_len = prs_shift;
        else if (r == IPV6_NXTH_OFS) hit = take_l4_proto(b, st);
        if (!hit && p + 1 == prs_l3_end) prs_phase = PH_L4;
      end
      PH_L4: begin
        r = (p - prs_l3_end) & 255;
        if (prs_proto == IP_PROTO_TCP && r == TCP_DOFF_OFS) begin
          doff = {b[7:4], 2'b00};
          if (prs_len < doff) begin
            hit = 1'b1;
            st  = ST_SHORT;
          end else begin
            prs_len    = prs_len - doff;
            prs_l4_end = prs_l3_end + doff;
            prs_l4     = L4_TCP;
          end
        end
        // a short TCP header may already be behind us on the offset byte
        if (!hit && prs_l4 != L4_NONE && p + 1 >= prs_l4_end) begin
          hit = 1'b1;
          st  = ST_OK;
        end
      end
      default: begin
        prs_phase = PH_IDLE;
        return;
      end
    endcase

    prs_pos = (p < BYTE_POS_MAX) ? p + 1 : BYTE_POS_MAX;

    if (!hit && eop) begin
      hit = 1'b1;
      st  = ST_TRUNC;
    end
    if (eop) prs_phase = PH_IDLE;
    if (!hit) return;

    res.status         = st;
    res.payload_offset = (st == ST_OK) ? prs_l4_end : 8'd0;
    res.payload_length = (st == ST_OK) ? prs_len : 16'd0;
    res.l2_kind        = prs_l2;
    res.l3_kind        = prs_l3;
    res.l4_kind        = prs_l4;
    pending_results.push_back(res);
    prs_done  = 1'b1;
    prs_phase = PH_IDLE;
  endfunction

  // -------------------------------------------------------------------------
  // Frame construction
  // -------------------------------------------------------------------------
  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // IP length that exactly covers the headers plus the payload bytes sent.
  function automatic int exact_len(input bit v6, input int ihl, input logic [7:0] proto,
                                   input int doff, input int tail);
    int span;
    span = (proto == IP_PROTO_TCP) ? doff * 4 : (proto == IP_PROTO_UDP) ? UDP_HDR_LEN : 0;
    return (v6 ? 0 : ihl * 4) + span + tail;
  endfunction

  // Builds a frame in 'frame': MACs, 'tags' VLAN tags, IPv4 or IPv6, then the
  // L4 header and 'tail' payload bytes. All free fields are random.
  task automatic build_frame(input int tags, input bit v6, input int ihl,
                             input logic [7:0] proto, input int doff,
                             input int ip_len, input int tail);
    logic [15:0] len16;
    int          tcp_hdr;
    len16   = ip_len[15:0];
    tcp_hdr = (doff * 4 > 20) ? doff * 4 : 20;
    frame.delete();
    repeat (12) frame.push_back(rnd_byte());
    repeat (tags) begin
      frame.push_back(ETYPE_VLAN[15:8]);
      frame.push_back(ETYPE_VLAN[7:0]);
      repeat (2) frame.push_back(rnd_byte());
    end
    if (!v6) begin
      frame.push_back(ETYPE_IPV4[15:8]);
      frame.push_back(ETYPE_IPV4[7:0]);
      // version nibble left random, the parser ignores it
      frame.push_back((rnd_byte() & 8'hf0) | 8'(ihl & 15));
      frame.push_back(rnd_byte());
      frame.push_back(len16[15:8]);
      frame.push_back(len16[7:0]);
      repeat (5) frame.push_back(rnd_byte());
      frame.push_back(proto);
      repeat (10) frame.push_back(rnd_byte());
      if (ihl > 5) repeat ((ihl - 5) * 4) frame.push_back(rnd_byte());
    end else begin
      frame.push_back(ETYPE_IPV6[15:8]);
      frame.push_back(ETYPE_IPV6[7:0]);
      repeat (4) frame.push_back(rnd_byte());
      frame.push_back(len16[15:8]);
      frame.push_back(len16[7:0]);
      frame.push_back(proto);
      repeat (33) frame.push_back(rnd_byte());
    end
    if (proto == IP_PROTO_TCP) begin
      repeat (12) frame.push_back(rnd_byte());
      frame.push_back(8'((doff & 15) << 4) | (rnd_byte() & 8'h0f));
      repeat (tcp_hdr - 13) frame.push_back(rnd_byte());
    end else if (proto == IP_PROTO_UDP) begin
      repeat (8) frame.push_back(rnd_byte());
    end else begin
      repeat (4) frame.push_back(rnd_byte());
    end
    repeat (tail) frame.push_back(rnd_byte());
  endtask

  // Queues the first 'keep' bytes of the frame (all of it when keep is 0).
  task automatic send_frame(input int keep, input bit with_eop);
    int         n;
    wire_byte_t wb;
    n = (keep > 0 && keep < frame.size()) ? keep : frame.size();
    for (int i = 0; i < n; i++) begin
      wb.data = frame[i];
      wb.sop  = (i == 0);
      wb.eop  = with_eop && (i == n - 1);
      tx_bytes.push_back(wb);
    end
    sent_bytes += n;
  endtask

  // Stray bytes with no start of packet; the parser must drop them.
  task automatic send_loose(input int n);
    wire_byte_t wb;
    repeat (n) begin
      wb.data = rnd_byte();
      wb.sop  = 1'b0;
      wb.eop  = ($urandom_range(0, 2) == 0);
      tx_bytes.push_back(wb);
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: bursts of byte transactions separated by random gaps. Inputs
  // move on the falling edge; a stalled byte is held as it is.
  // -------------------------------------------------------------------------
  logic in_taken = 1'b0;   // last rising edge accepted a byte
  int   burst_left = 16;
  int   gap_left = 0;

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_parse(in_data_byte, in_start_of_packet, in_end_of_packet);
      void'(tx_bytes.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: keep the transaction on the wires
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (tx_bytes.size() != 0) begin
      in_valid           <= 1'b1;
      in_data_byte       <= tx_bytes[0].data;
      in_start_of_packet <= tx_bytes[0].sop;
      in_end_of_packet   <= tx_bytes[0].eop;
      burst_left--;
      if (burst_left <= 0) begin
        // now and then a long burst, so some packets go through unbroken
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // -------------------------------------------------------------------------
  // Sink: stall pattern switches between open, light, heavy and a comb
  // -------------------------------------------------------------------------
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ((rx_tick & 7) < 3);
    endcase
  end

  // -------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest prediction
  // -------------------------------------------------------------------------
  result_t rx_want;

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: st=%0d off=%0d len=%0d kinds=%0d/%0d/%0d",
                             out_status, out_payload_offset, out_payload_length,
                             out_l2_kind, out_l3_kind, out_l4_kind));
      end else begin
        rx_want = pending_results.pop_front();
        if (out_status !== rx_want.status ||
            out_payload_offset !== rx_want.payload_offset ||
            out_payload_length !== rx_want.payload_length ||
            out_l2_kind !== rx_want.l2_kind ||
            out_l3_kind !== rx_want.l3_kind ||
            out_l4_kind !== rx_want.l4_kind) begin
          note_error($sformatf({"result mismatch: exp st=%0d off=%0d len=%0d kinds=%0d/%0d/%0d,",
                                " got st=%0d off=%0d len=%0d kinds=%0d/%0d/%0d"},
                               rx_want.status, rx_want.payload_offset,
                               rx_want.payload_length, rx_want.l2_kind,
                               rx_want.l3_kind, rx_want.l4_kind,
                               out_status, out_payload_offset, out_payload_length,
                               out_l2_kind, out_l3_kind, out_l4_kind));
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: a hung handshake or a missing result ends here
  // -------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int          pick, sel, tags, ihl, doff, tail, ip_len, keep;
    bit          v6, with_eop;
    logic [7:0]  proto;
    logic [15:0] etype;

    // --- directed frames ---
    // bytes ahead of the first start of packet
    send_loose(3);
    // plain IPv4/TCP, last byte is the last TCP header byte: ok, not truncated
    build_frame(0, 0, 5, IP_PROTO_TCP, 5, exact_len(0, 5, IP_PROTO_TCP, 5, 0), 0);
    send_frame(0, 1);
    // single tag, IPv4/UDP
    build_frame(1, 0, 5, IP_PROTO_UDP, 5, exact_len(0, 5, IP_PROTO_UDP, 5, 3), 3);
    send_frame(0, 1);
    // QinQ, IPv6/TCP with the largest data offset
    build_frame(2, 1, 5, IP_PROTO_TCP, 15, exact_len(1, 5, IP_PROTO_TCP, 15, 2), 2);
    send_frame(0, 1);
    // third VLAN tag is refused
    build_frame(3, 0, 5, IP_PROTO_TCP, 5, 40, 0);
    send_frame(0, 1);
    // unsupported ethertype
    build_frame(0, 0, 5, IP_PROTO_TCP, 5, 40, 0);
    frame[12] = ETYPE_ARP[15:8];
    frame[13] = ETYPE_ARP[7:0];
    send_frame(0, 1);
    // IHL below the minimum, and zero
    build_frame(0, 0, 4, IP_PROTO_TCP, 5, 40, 0);
    send_frame(0, 1);
    build_frame(1, 0, 0, IP_PROTO_UDP, 5, 40, 0);
    send_frame(0, 1);
    // largest IHL with options, QinQ, UDP
    build_frame(2, 0, 15, IP_PROTO_UDP, 5, exact_len(0, 15, IP_PROTO_UDP, 5, 1), 1);
    send_frame(0, 1);
    // IPv4 total length shorter than its own header
    build_frame(0, 0, 6, IP_PROTO_TCP, 5, 23, 0);
    send_frame(0, 1);
    // unsupported protocol, both IP versions
    build_frame(0, 0, 5, PROTO_ICMP, 5, 40, 0);
    send_frame(0, 1);
    build_frame(0, 1, 5, PROTO_ICMP6, 5, 40, 0);
    send_frame(0, 1);
    // UDP with fewer than eight bytes left, both IP versions
    build_frame(0, 0, 5, IP_PROTO_UDP, 5, 27, 0);
    send_frame(0, 1);
    build_frame(1, 1, 5, IP_PROTO_UDP, 5, 7, 0);
    send_frame(0, 1);
    // TCP with less left than its data offset
    build_frame(0, 0, 5, IP_PROTO_TCP, 5, 39, 0);
    send_frame(0, 1);
    // tiny data offsets: header end already passed at the offset byte
    build_frame(0, 0, 5, IP_PROTO_TCP, 0, 20, 4);
    send_frame(0, 1);
    build_frame(0, 1, 5, IP_PROTO_TCP, 3, 12, 4);
    send_frame(0, 1);
    // all-ones length fields
    build_frame(0, 0, 5, IP_PROTO_TCP, 5, 16'hffff, 2);
    send_frame(0, 1);
    build_frame(2, 1, 5, IP_PROTO_UDP, 5, 16'hffff, 0);
    send_frame(0, 1);
    // end of packet inside the IP header
    build_frame(0, 0, 5, IP_PROTO_TCP, 5, 40, 0);
    send_frame(30, 1);
    // start and end on the same byte
    build_frame(0, 0, 5, IP_PROTO_TCP, 5, 40, 0);
    send_frame(1, 1);
    // stray bytes between packets
    send_loose(4);
    // new start of packet before the result
    build_frame(0, 0, 5, IP_PROTO_UDP, 5, exact_len(0, 5, IP_PROTO_UDP, 5, 6), 6);
    send_frame(20, 0);
    // no end of packet: payload bytes after the result are dropped
    build_frame(1, 0, 5, IP_PROTO_TCP, 5, exact_len(0, 5, IP_PROTO_TCP, 5, 8), 8);
    send_frame(0, 0);
    build_frame(0, 1, 5, IP_PROTO_UDP, 5, exact_len(1, 5, IP_PROTO_UDP, 5, 0), 0);
    send_frame(0, 1);

    // --- random frames: mostly well formed, the rest broken or cut short ---
    while (sent_bytes < MIN_BYTES || frames_sent < MIN_FRAMES) begin
      pick  = $urandom_range(0, 99);
      tags  = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
      v6    = $urandom_range(0, 1);
      ihl   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4)
            : ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(5, 15);
      sel   = $urandom_range(0, 19);
      proto = (sel < 9) ? IP_PROTO_TCP : (sel < 18) ? IP_PROTO_UDP : rnd_byte();
      doff  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      tail  = $urandom_range(0, 12);
      ip_len = exact_len(v6, ihl, proto, doff, tail);
      sel = $urandom_range(0, 19);
      if (sel < 3) ip_len = $urandom_range(ip_len, 65535);
      else if (sel < 6) ip_len = $urandom_range(0, 65535);
      else if (sel < 8) ip_len = $urandom_range(0, ip_len);
      build_frame(tags, v6, ihl, proto, doff, ip_len, tail);

      if (pick < 6) begin
        do etype = $urandom_range(0, 65535);
        while (etype == ETYPE_VLAN || etype == ETYPE_IPV4 || etype == ETYPE_IPV6);
        frame[12 + 4 * tags]     = etype[15:8];
        frame[12 + 4 * tags + 1] = etype[7:0];
      end

      keep     = 0;
      with_eop = 1'b1;
      if (pick >= 6 && pick < 14) keep = $urandom_range(1, frame.size());
      else if (pick >= 14 && pick < 17) keep = 1;
      else if (pick >= 17 && pick < 25) with_eop = 1'b0;
      send_frame(keep, with_eop);
      frames_sent++;
      if ($urandom_range(0, 19) == 0) send_loose($urandom_range(1, 4));
    end

    // --- reset, then let the driver and monitor run ---
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (tx_bytes.size() != 0 || pending_results.size() != 0) @(negedge clk);
    // room for any result that should not be there
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
